// File: rtl/core/tcb_pkg.sv
// shared constants, types and register codes of the tcb spline point evaluator
`default_nettype none

package tcb_pkg;

  // coordinate width default, signed fixed point
  localparam int COORD_WIDTH_DEF = 16;

  // segment parameter, unsigned q0.16 with one bit of headroom for 1.0
  localparam int U_FRAC = 16;
  localparam int U_W    = U_FRAC + 1;
  localparam int U_ONE  = 1 << U_FRAC;

  // shape settings, signed q2.14
  localparam int SHAPE_FRAC = 14;
  localparam int SHAPE_W    = 16;
  localparam int SHAPE_ONE  = 1 << SHAPE_FRAC;

  // basis weights q16 and tangent weights q14, both signed
  localparam int H_W  = 18;
  localparam int WT_W = 20;

  // pipeline depth, output register included
  localparam int STAGES = 7;

  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TENSION    = 2'd0,
    CFG_CONTINUITY = 2'd1,
    CFG_BIAS       = 2'd2
  } cfg_reg_t;

  typedef logic signed [SHAPE_W-1:0] shape_t;
  typedef logic signed [H_W-1:0]     basis_t;
  typedef logic signed [WT_W-1:0]    weight_t;
  typedef logic [STAGES-1:0]         stage_vec_t;

  typedef struct packed {
    shape_t tension;
    shape_t continuity;
    shape_t bias;
  } shape_cfg_t;

  // hermite basis weights
  typedef struct packed {
    basis_t h00;
    basis_t h01;
    basis_t h10;
    basis_t h11;
  } basis_set_t;

  // tangent weights: outgoing tangent on p1-p0 and p2-p1, incoming on p2-p1 and p3-p2
  typedef struct packed {
    weight_t ts_prev;
    weight_t ts_next;
    weight_t td_prev;
    weight_t td_next;
  } weight_set_t;

endpackage

`default_nettype wire

// File: rtl/core/tcb_if.sv
// point and result channel interfaces of the tcb spline point evaluator
`default_nettype none

interface tcb_point_if #(
  parameter int COORD_WIDTH = tcb_pkg::COORD_WIDTH_DEF
) ();
  import tcb_pkg::*;

  logic                          valid;
  logic                          ready;
  logic [U_W-1:0]                u_param;
  logic signed [COORD_WIDTH-1:0] p0_x;
  logic signed [COORD_WIDTH-1:0] p0_y;
  logic signed [COORD_WIDTH-1:0] p1_x;
  logic signed [COORD_WIDTH-1:0] p1_y;
  logic signed [COORD_WIDTH-1:0] p2_x;
  logic signed [COORD_WIDTH-1:0] p2_y;
  logic signed [COORD_WIDTH-1:0] p3_x;
  logic signed [COORD_WIDTH-1:0] p3_y;

  modport source (
    output valid, u_param, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y,
    input  ready
  );

  modport sink (
    input  valid, u_param, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y,
    output ready
  );
endinterface

interface tcb_result_if #(
  parameter int COORD_WIDTH = tcb_pkg::COORD_WIDTH_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] out_x;
  logic signed [COORD_WIDTH-1:0] out_y;

  modport source (
    output valid, out_x, out_y,
    input  ready
  );

  modport sink (
    input  valid, out_x, out_y,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/core/tcb_basis.sv
// hermite basis weights from the segment parameter, three stages
`default_nettype none

module tcb_basis (
  input  logic                     clk,
  input  tcb_pkg::stage_vec_t      en,
  input  logic [tcb_pkg::U_W-1:0]  u_param,
  output tcb_pkg::basis_set_t      basis
);
  import tcb_pkg::*;

  localparam int U2_W  = 2 * U_W - 1;   // holds 1.0 squared
  localparam int U3_W  = 3 * U_W - 2;   // holds 1.0 cubed
  localparam int ACC_W = U3_W + 3;
  localparam int RSH   = 2 * U_FRAC;

  localparam logic signed [ACC_W-1:0] HALF    = ACC_W'(1) << (RSH - 1);
  localparam logic signed [ACC_W-1:0] ONE_Q48 = ACC_W'(1) << (3 * U_FRAC);

  logic [U_W-1:0]       u_sat;
  logic [2*U_W-1:0]     sq;
  logic [U2_W+U_W-1:0]  cube;

  logic [U_W-1:0]       s1_u;
  logic [U2_W-1:0]      s1_u2;
  logic [U_W-1:0]       s2_u;
  logic [U2_W-1:0]      s2_u2;
  logic [U3_W-1:0]      s2_u3;

  logic signed [ACC_W-1:0] c3, q2, u1;
  logic signed [ACC_W-1:0] r00, r01, r10, r11;

  // u above one clamps to one
  assign u_sat = (u_param > U_W'(U_ONE)) ? U_W'(U_ONE) : u_param;
  assign sq    = u_sat * u_sat;
  assign cube  = s1_u2 * s1_u;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_u  <= u_sat;
      s1_u2 <= sq[U2_W-1:0];
    end
    if (en[1]) begin
      s2_u  <= s1_u;
      s2_u2 <= s1_u2;
      s2_u3 <= cube[U3_W-1:0];
    end
  end

  // all terms in q48
  assign c3 = $signed(ACC_W'(s2_u3));
  assign q2 = $signed(ACC_W'(s2_u2) << U_FRAC);
  assign u1 = $signed(ACC_W'(s2_u) << (2 * U_FRAC));

  assign r00 = (c3 <<< 1) - q2 - (q2 <<< 1) + ONE_Q48 + HALF;
  assign r01 = q2 + (q2 <<< 1) - (c3 <<< 1) + HALF;
  assign r10 = c3 - (q2 <<< 1) + u1 + HALF;
  assign r11 = c3 - q2 + HALF;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      basis.h00 <= r00[RSH +: H_W];
      basis.h01 <= r01[RSH +: H_W];
      basis.h10 <= r10[RSH +: H_W];
      basis.h11 <= r11[RSH +: H_W];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/tcb_shape.sv
// tangent weights from tension, continuity and bias, three stages
`default_nettype none

module tcb_shape (
  input  logic                 clk,
  input  tcb_pkg::stage_vec_t  en,
  input  tcb_pkg::shape_cfg_t  cfg,
  output tcb_pkg::weight_set_t weights
);
  import tcb_pkg::*;

  localparam int F_W = SHAPE_W + 2;          // one minus or plus a setting
  localparam int Q_W = 2 * F_W;
  localparam int T_W = 3 * F_W;
  localparam int P_W = 3 * SHAPE_FRAC + 8;   // triple product magnitude below 2^47
  localparam int WSH = 2 * SHAPE_FRAC + 1;   // q42 halved back to q14

  localparam logic signed [P_W-1:0] HALF = P_W'(1) << (WSH - 1);

  logic signed [F_W-1:0] a, bp, bm, cp, cm;
  logic signed [Q_W-1:0] s1_abp, s1_abm;
  logic signed [F_W-1:0] s1_cp, s1_cm;
  logic signed [T_W-1:0] t_ts_prev, t_ts_next, t_td_prev, t_td_next;
  logic signed [P_W-1:0] s2_ts_prev, s2_ts_next, s2_td_prev, s2_td_next;
  logic signed [P_W-1:0] r_ts_prev, r_ts_next, r_td_prev, r_td_next;

  assign a  = F_W'(SHAPE_ONE) - F_W'(cfg.tension);
  assign bp = F_W'(SHAPE_ONE) + F_W'(cfg.bias);
  assign bm = F_W'(SHAPE_ONE) - F_W'(cfg.bias);
  assign cp = F_W'(SHAPE_ONE) + F_W'(cfg.continuity);
  assign cm = F_W'(SHAPE_ONE) - F_W'(cfg.continuity);

  assign t_ts_prev = s1_abp * s1_cm;
  assign t_ts_next = s1_abm * s1_cp;
  assign t_td_prev = s1_abp * s1_cp;
  assign t_td_next = s1_abm * s1_cm;

  assign r_ts_prev = s2_ts_prev + HALF;
  assign r_ts_next = s2_ts_next + HALF;
  assign r_td_prev = s2_td_prev + HALF;
  assign r_td_next = s2_td_next + HALF;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_abp <= a * bp;
      s1_abm <= a * bm;
      s1_cp  <= cp;
      s1_cm  <= cm;
    end
    if (en[1]) begin
      s2_ts_prev <= t_ts_prev[P_W-1:0];
      s2_ts_next <= t_ts_next[P_W-1:0];
      s2_td_prev <= t_td_prev[P_W-1:0];
      s2_td_next <= t_td_next[P_W-1:0];
    end
    if (en[2]) begin
      weights.ts_prev <= r_ts_prev[WSH +: WT_W];
      weights.ts_next <= r_ts_next[WSH +: WT_W];
      weights.td_prev <= r_td_prev[WSH +: WT_W];
      weights.td_next <= r_td_next[WSH +: WT_W];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/tcb_lane.sv
// one coordinate axis: differences, tangents, hermite sum, rounding and saturation
`default_nettype none

module tcb_lane #(
  parameter int COORD_WIDTH = tcb_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  tcb_pkg::stage_vec_t           en,
  input  logic signed [COORD_WIDTH-1:0] q0,
  input  logic signed [COORD_WIDTH-1:0] q1,
  input  logic signed [COORD_WIDTH-1:0] q2,
  input  logic signed [COORD_WIDTH-1:0] q3,
  input  tcb_pkg::basis_set_t           basis,
  input  tcb_pkg::weight_set_t          weights,
  output logic signed [COORD_WIDTH-1:0] result
);
  import tcb_pkg::*;

  localparam int D_W     = COORD_WIDTH + 1;
  localparam int M_W     = WT_W + D_W;
  localparam int TS_W    = M_W + 2;
  localparam int TAN_SH  = SHAPE_FRAC - 2;   // tangents keep two extra fraction bits
  localparam int T_W     = TS_W - TAN_SH;
  localparam int G_W     = H_W + COORD_WIDTH;
  localparam int B_W     = G_W + 3;
  localparam int E_W     = H_W + T_W;
  localparam int ACC_W   = E_W + 2;
  localparam int OUT_SH  = U_FRAC + 2;
  localparam int R_W     = ACC_W - OUT_SH;

  localparam logic signed [TS_W-1:0]  T_HALF = TS_W'(1) << (TAN_SH - 1);
  localparam logic signed [ACC_W-1:0] O_HALF = ACC_W'(1) << (OUT_SH - 1);
  localparam logic signed [R_W-1:0]   R_MAX  =
    {{(R_W-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [R_W-1:0]   R_MIN  =
    {{(R_W-COORD_WIDTH+1){1'b1}}, {(COORD_WIDTH-1){1'b0}}};

  logic signed [D_W-1:0]         s1_d0, s1_d1, s1_d2, s2_d0, s2_d1, s2_d2;
  logic signed [D_W-1:0]         s3_d0, s3_d1, s3_d2;
  logic signed [COORD_WIDTH-1:0] s1_q1, s1_q2, s2_q1, s2_q2, s3_q1, s3_q2;
  logic signed [M_W-1:0]         s4_m0, s4_m1, s4_m2, s4_m3;
  logic signed [G_W-1:0]         s4_g1, s4_g2;
  basis_t                        s4_h10, s4_h11, s5_h10, s5_h11;
  logic signed [TS_W-1:0]        sum_ts, sum_td;
  logic signed [B_W-1:0]         base;
  logic signed [T_W-1:0]         s5_ts, s5_td;
  logic signed [B_W-1:0]         s5_base, s6_base;
  logic signed [E_W-1:0]         s6_e2, s6_e3;
  logic signed [ACC_W-1:0]       acc;
  logic signed [R_W-1:0]         rounded;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_d0 <= D_W'(q1) - D_W'(q0);
      s1_d1 <= D_W'(q2) - D_W'(q1);
      s1_d2 <= D_W'(q3) - D_W'(q2);
      s1_q1 <= q1;
      s1_q2 <= q2;
    end
    if (en[1]) begin
      s2_d0 <= s1_d0;
      s2_d1 <= s1_d1;
      s2_d2 <= s1_d2;
      s2_q1 <= s1_q1;
      s2_q2 <= s1_q2;
    end
    if (en[2]) begin
      s3_d0 <= s2_d0;
      s3_d1 <= s2_d1;
      s3_d2 <= s2_d2;
      s3_q1 <= s2_q1;
      s3_q2 <= s2_q2;
    end
    if (en[3]) begin
      s4_m0  <= weights.ts_prev * s3_d0;
      s4_m1  <= weights.ts_next * s3_d1;
      s4_m2  <= weights.td_prev * s3_d1;
      s4_m3  <= weights.td_next * s3_d2;
      s4_g1  <= basis.h00 * s3_q1;
      s4_g2  <= basis.h01 * s3_q2;
      s4_h10 <= basis.h10;
      s4_h11 <= basis.h11;
    end
    if (en[4]) begin
      s5_ts   <= sum_ts[TAN_SH +: T_W];
      s5_td   <= sum_td[TAN_SH +: T_W];
      s5_base <= base;
      s5_h10  <= s4_h10;
      s5_h11  <= s4_h11;
    end
    if (en[5]) begin
      s6_e2   <= s5_h10 * s5_ts;
      s6_e3   <= s5_h11 * s5_td;
      s6_base <= s5_base;
    end
  end

  // tangents rounded half up to two extra fraction bits
  assign sum_ts = TS_W'(s4_m0) + TS_W'(s4_m1) + T_HALF;
  assign sum_td = TS_W'(s4_m2) + TS_W'(s4_m3) + T_HALF;

  // point terms lifted to the tangent fraction
  assign base = (B_W'(s4_g1) + B_W'(s4_g2)) <<< 2;

  assign acc     = ACC_W'(s6_base) + ACC_W'(s6_e2) + ACC_W'(s6_e3) + O_HALF;
  assign rounded = acc[ACC_W-1:OUT_SH];

  always_comb begin
    if (rounded > R_MAX) begin
      result = R_MAX[COORD_WIDTH-1:0];
    end else if (rounded < R_MIN) begin
      result = R_MIN[COORD_WIDTH-1:0];
    end else begin
      result = rounded[COORD_WIDTH-1:0];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/tcb_spline_point_eval.sv
// top level of the tcb spline point evaluator: controls, shared coefficient units, two axis lanes
//
//   channel     dir  handshake      payload
//   point_in    in   valid/ready    u_param, p0_x .. p3_y
//   point_out   out  valid/ready    out_x, out_y
//   cfg_*       in   cfg_wen only   cfg_idx, cfg_wdata (tension, continuity, bias)
//
// one word accepted per cycle when the output side keeps up;
// the rate is set by nothing but the stage handshake
// result word passes through the lane stages and the merge stage before it shows on point_out
// each stage stalls on its own, so bubbles close up while a result waits
// synchronous active-high reset empties the pipeline and clears the shape settings to zero
`default_nettype none

module tcb_spline_point_eval #(
  parameter int COORD_WIDTH = tcb_pkg::COORD_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  tcb_point_if.sink                       point_in,
  tcb_result_if.source                    point_out,
  input  logic                            cfg_wen,
  input  logic [tcb_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [tcb_pkg::SHAPE_W-1:0]     cfg_wdata
);
  import tcb_pkg::*;

  // stage occupancy and load enables, index 0 is the entry stage
  stage_vec_t v;
  stage_vec_t en;

  shape_cfg_t  shape;
  basis_set_t  basis;
  weight_set_t weights;

  logic signed [COORD_WIDTH-1:0] lane_x, lane_y;
  logic signed [COORD_WIDTH-1:0] x_word, y_word;

  logic in_fire, out_fire;

  // a stage loads when it is empty or its word moves on
  assign en[STAGES-1] = !v[STAGES-1] || point_out.ready;
  for (genvar k = 0; k < STAGES - 1; k++) begin : g_en
    assign en[k] = !v[k] || en[k+1];
  end

  assign point_in.ready = en[0];
  assign in_fire        = point_in.valid && en[0];
  assign out_fire       = v[STAGES-1] && point_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= in_fire;
      end
      for (int k = 1; k < STAGES; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // shape settings, writes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      shape <= '0;
    end else if (cfg_wen) begin
      unique case (cfg_idx)
        CFG_TENSION:    shape.tension    <= cfg_wdata;
        CFG_CONTINUITY: shape.continuity <= cfg_wdata;
        CFG_BIAS:       shape.bias       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // basis and tangent weights are shared by both lanes, ready for stage four
  tcb_basis u_basis (
    .clk     (clk),
    .en      (en),
    .u_param (point_in.u_param),
    .basis   (basis)
  );

  tcb_shape u_shape (
    .clk     (clk),
    .en      (en),
    .cfg     (shape),
    .weights (weights)
  );

  tcb_lane #(.COORD_WIDTH(COORD_WIDTH)) u_lane_x (
    .clk     (clk),
    .en      (en),
    .q0      (point_in.p0_x),
    .q1      (point_in.p1_x),
    .q2      (point_in.p2_x),
    .q3      (point_in.p3_x),
    .basis   (basis),
    .weights (weights),
    .result  (lane_x)
  );

  tcb_lane #(.COORD_WIDTH(COORD_WIDTH)) u_lane_y (
    .clk     (clk),
    .en      (en),
    .q0      (point_in.p0_y),
    .q1      (point_in.p1_y),
    .q2      (point_in.p2_y),
    .q3      (point_in.p3_y),
    .basis   (basis),
    .weights (weights),
    .result  (lane_y)
  );

  // merge stage: both axes land in one output word
  always_ff @(posedge clk) begin
    if (en[STAGES-1]) begin
      x_word <= lane_x;
      y_word <= lane_y;
    end
  end

  assign point_out.valid = v[STAGES-1];
  assign point_out.out_x = x_word;
  assign point_out.out_y = y_word;

  // a stage that could not move keeps its word
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> ((v & $past(v & ~en)) == $past(v & ~en)))
    else $error("stalled stage lost its word");

  // words in flight change only by accepted inputs and taken results
  a_conserve: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> ($countones(v) ==
      $past($countones(v)) + int'($past(in_fire)) - int'($past(out_fire))))
    else $error("pipeline occupancy out of step with handshakes");

  // a result only appears when the last lane stage held a word
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    $rose(v[STAGES-1]) |-> $past(v[STAGES-2]))
    else $error("result word appeared from an empty stage");

endmodule

`default_nettype wire

// File: dv/tcb_spline_point_eval_tb.sv
// self-checking testbench for the tcb spline point evaluator with a fixed-point predictor
`default_nettype none

module tcb_spline_point_eval_tb;
  import tcb_pkg::*;

  localparam int COORD_W = COORD_WIDTH_DEF;

  // register index that the block must ignore
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  // how each directed row gets its expected word
  localparam logic ROW_FIXED = 1'b1;   // typed into the table
  localparam logic ROW_CALC  = 1'b0;   // worked out by the predictor

  localparam longint COORD_MAX = (longint'(1) <<< (COORD_W - 1)) - 1;
  localparam longint COORD_MIN = -COORD_MAX - 1;

  // run length and pressure
  localparam int N_DIRECTED   = 14;
  localparam int N_PHASES     = 7;
  localparam int PHASE_WORDS  = 236;
  localparam int HOLD_AFTER   = 1000;  // results seen before the long receiver hold-off
  localparam int HOLD_CYCLES  = 120;
  localparam int CYCLE_LIMIT  = 200000;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic [U_W-1:0] u;
    coord_t         p0_x;
    coord_t         p0_y;
    coord_t         p1_x;
    coord_t         p1_y;
    coord_t         p2_x;
    coord_t         p2_y;
    coord_t         p3_x;
    coord_t         p3_y;
  } point_word_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } result_word_t;

  typedef struct packed {
    point_word_t  pt;
    logic         known;
    result_word_t res;
  } stim_row_t;

  // directed rows: ends of the segment, u beyond one, coordinate extremes,
  // overshoot into saturation on both sides, an exact straight line, and five rows for the predictor
  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    // u at zero gives p1
    '{'{0,      100, -200, 4096, -4096, 8192, 2048, -1000, 3000}, ROW_FIXED, '{4096, -4096}},
    // u at one gives p2
    '{'{65536,  100, -200, 4096, -4096, 8192, 2048, -1000, 3000}, ROW_FIXED, '{8192, 2048}},
    // u beyond one is clipped to one
    '{'{131071, 100, -200, 4096, -4096, 8192, 2048, -1000, 3000}, ROW_FIXED, '{8192, 2048}},
    '{'{65537,  100, -200, 4096, -4096, 8192, 2048, -1000, 3000}, ROW_FIXED, '{8192, 2048}},
    // all coordinates at the negative extreme
    '{'{0, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768},
      ROW_FIXED, '{-32768, -32768}},
    // all coordinates at the positive extreme
    '{'{65536, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767},
      ROW_FIXED, '{32767, 32767}},
    // tangents push the midpoint above the range
    '{'{32768, -32768, -32768, 32767, 32767, 32767, 32767, -32768, -32768},
      ROW_FIXED, '{32767, 32767}},
    // and below it
    '{'{32768, 32767, 32767, -32768, -32768, -32768, -32768, 32767, 32767},
      ROW_FIXED, '{-32768, -32768}},
    // evenly spaced points on a line, quarter way along
    '{'{16384, 0, 0, 4096, 0, 8192, 0, 12288, 0}, ROW_FIXED, '{5120, 0}},
    '{'{32768, 1000, -3000, 5000, 2500, -7000, 9000, 300, -12000}, ROW_CALC, '{0, 0}},
    '{'{1,     32767, -32768, -32768, 32767, 32767, -32768, -32768, 32767}, ROW_CALC, '{0, 0}},
    '{'{65535, 32767, -32768, -32768, 32767, 32767, -32768, -32768, 32767}, ROW_CALC, '{0, 0}},
    '{'{21845, -20000, 15000, 12345, -23456, 31000, -31000, -5, 7}, ROW_CALC, '{0, 0}},
    '{'{43690, 0, 0, -1, -1, 1, 1, 2, -2}, ROW_CALC, '{0, 0}}
  };

  // shape settings walked by the random phases; the last one is drawn at random
  localparam shape_cfg_t SHAPE_PLAN [N_PHASES-1] = '{
    '{0, 0, 0},
    '{16384, 16384, 16384},
    '{-16384, -16384, -16384},
    '{16'sh8000, 16'sh8000, 16'sh8000},
    '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF},
    '{-16384, 16384, -16384}
  };

  logic                 clk;
  logic                 rst;
  logic                 cfg_wen;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [SHAPE_W-1:0]   cfg_wdata;

  tcb_point_if  #(.COORD_WIDTH(COORD_W)) pt_if ();
  tcb_result_if #(.COORD_WIDTH(COORD_W)) res_if ();

  tcb_spline_point_eval #(.COORD_WIDTH(COORD_W)) u_top (
    .clk       (clk),
    .rst       (rst),
    .point_in  (pt_if),
    .point_out (res_if),
    .cfg_wen   (cfg_wen),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // shadow of the shape registers, as the block should hold them
  shape_cfg_t   shape_regs;

  stim_row_t    pending_points[$];   // words waiting to be offered
  result_word_t expected_points[$];  // predicted words, oldest first

  int tx_idle_pct;
  int rx_idle_pct;
  int results_seen;
  int mismatch_count;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // round half up, dropping s fraction bits
  function automatic longint round_drop(input longint v, input int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  // one axis: tangents from neighbouring differences, then the hermite blend
  function automatic coord_t blend_axis(input longint h0, h1, h2, h3,
                                        input longint w0, w1, w2, w3,
                                        input longint q0, q1, q2, q3);
    longint ts, td, acc, r;
    ts  = round_drop(w0 * (q1 - q0) + w1 * (q2 - q1), SHAPE_FRAC - 2);
    td  = round_drop(w2 * (q2 - q1) + w3 * (q3 - q2), SHAPE_FRAC - 2);
    acc = (h0 * q1 + h1 * q2) * 4 + h2 * ts + h3 * td;
    r   = round_drop(acc, U_FRAC + 2);
    if (r > COORD_MAX) begin
      r = COORD_MAX;
    end else if (r < COORD_MIN) begin
      r = COORD_MIN;
    end
    return coord_t'(r);
  endfunction

  function automatic result_word_t predict_point(input point_word_t pt);
    longint u, u2, u3, h0, h1, h2, h3;
    longint a, bp, bm, cp, cm, w0, w1, w2, w3;
    result_word_t res;
    u = pt.u;
    if (u > U_ONE) begin
      u = U_ONE;
    end
    u2 = u * u;
    u3 = u2 * u;
    // basis weights exact in q48, rounded to q16
    h0 = round_drop(2 * u3 - 3 * u2 * U_ONE + (longint'(1) <<< 48), 32);
    h1 = round_drop(-2 * u3 + 3 * u2 * U_ONE, 32);
    h2 = round_drop(u3 - 2 * u2 * U_ONE + u * (longint'(1) <<< 32), 32);
    h3 = round_drop(u3 - u2 * U_ONE, 32);
    // (1-t)(1+-b)(1+-c)/2, triple product in q42 rounded to q14
    a  = SHAPE_ONE - longint'(shape_regs.tension);
    bp = SHAPE_ONE + longint'(shape_regs.bias);
    bm = SHAPE_ONE - longint'(shape_regs.bias);
    cp = SHAPE_ONE + longint'(shape_regs.continuity);
    cm = SHAPE_ONE - longint'(shape_regs.continuity);
    w0 = round_drop(a * bp * cm, 2 * SHAPE_FRAC + 1);
    w1 = round_drop(a * bm * cp, 2 * SHAPE_FRAC + 1);
    w2 = round_drop(a * bp * cp, 2 * SHAPE_FRAC + 1);
    w3 = round_drop(a * bm * cm, 2 * SHAPE_FRAC + 1);
    res.x = blend_axis(h0, h1, h2, h3, w0, w1, w2, w3, pt.p0_x, pt.p1_x, pt.p2_x, pt.p3_x);
    res.y = blend_axis(h0, h1, h2, h3, w0, w1, w2, w3, pt.p0_y, pt.p1_y, pt.p2_y, pt.p3_y);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // random points: half roughly straight lines, some noise, some extremes
  // ---------------------------------------------------------------------------

  function automatic point_word_t random_point();
    point_word_t pt;
    coord_t      c[8];
    int          base[2];
    int          step[2];
    int          kind;
    kind = $urandom_range(9);
    for (int j = 0; j < 2; j++) begin
      base[j] = int'($urandom_range(32000)) - 16000;
      step[j] = int'($urandom_range(8000)) - 4000;
    end
    for (int k = 0; k < 8; k++) begin
      if (kind < 5) begin
        // points roughly evenly spaced along a line, with a little jitter
        c[k] = coord_t'(base[k % 2] + (k / 2) * step[k % 2] + int'($urandom_range(512)) - 256);
      end else if (kind < 8) begin
        c[k] = coord_t'($urandom);
      end else begin
        case ($urandom_range(4))
          0:       c[k] = 16'sh8000;
          1:       c[k] = 16'sh7FFF;
          2:       c[k] = '0;
          3:       c[k] = '1;
          default: c[k] = coord_t'($urandom);
        endcase
      end
    end
    case ($urandom_range(9))
      0:       pt.u = U_W'(U_ONE);
      1:       pt.u = U_W'($urandom_range(131071, U_ONE + 1));  // beyond one
      2:       pt.u = U_W'($urandom_range(3));
      default: pt.u = U_W'($urandom_range(U_ONE));
    endcase
    pt.p0_x = c[0];
    pt.p0_y = c[1];
    pt.p1_x = c[2];
    pt.p1_y = c[3];
    pt.p2_x = c[4];
    pt.p2_y = c[5];
    pt.p3_x = c[6];
    pt.p3_y = c[7];
    return pt;
  endfunction

  // ---------------------------------------------------------------------------
  // clock and run limit
  // ---------------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // hang guard: fails the run if the pipeline locks up
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // point side: offers queued words, queues the expected word for each one as it is taken
  // ---------------------------------------------------------------------------

  initial begin : point_sender
    stim_row_t row;
    pt_if.valid <= 1'b0;
    {pt_if.u_param, pt_if.p0_x, pt_if.p0_y, pt_if.p1_x, pt_if.p1_y,
     pt_if.p2_x, pt_if.p2_y, pt_if.p3_x, pt_if.p3_y} <= '0;
    forever begin
      @(posedge clk);
      if (pt_if.valid && pt_if.ready) begin
        row = pending_points.pop_front();
        if (row.known) begin
          expected_points.push_back(row.res);
        end else begin
          expected_points.push_back(predict_point(row.pt));
        end
      end
      if (pt_if.valid && !pt_if.ready) begin
        // word still on offer, keep it steady
      end else if (pending_points.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        pt_if.valid <= 1'b1;
        {pt_if.u_param, pt_if.p0_x, pt_if.p0_y, pt_if.p1_x, pt_if.p1_y,
         pt_if.p2_x, pt_if.p2_y, pt_if.p3_x, pt_if.p3_y} <= pending_points[0].pt;
      end else begin
        pt_if.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result side: checks each word taken, drives ready with random stalls and
  // one long hold-off so the pipeline fills and back-pressures the input
  // ---------------------------------------------------------------------------

  initial begin : result_checker
    result_word_t want;
    int           hold_left;
    bit           held_once;
    hold_left = 0;
    held_once = 1'b0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (res_if.valid && res_if.ready) begin
        if (expected_points.size() == 0) begin
          $error("result word with nothing expected: out_x=%0d out_y=%0d",
                 res_if.out_x, res_if.out_y);
          mismatch_count++;
        end else begin
          want = expected_points.pop_front();
          if (res_if.out_x !== want.x) begin
            $error("out_x expected %0d actual %0d", want.x, res_if.out_x);
            mismatch_count++;
          end
          if (res_if.out_y !== want.y) begin
            $error("out_y expected %0d actual %0d", want.y, res_if.out_y);
            mismatch_count++;
          end
        end
        results_seen++;
      end
      if (hold_left > 0) begin
        res_if.ready <= 1'b0;
        hold_left--;
      end else if (!held_once && results_seen >= HOLD_AFTER) begin
        held_once = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // register writes and phase control
  // ---------------------------------------------------------------------------

  task automatic write_shape_reg(input logic [CFG_IDX_W-1:0] idx, input shape_t val);
    @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_TENSION:    shape_regs.tension    = val;
      CFG_CONTINUITY: shape_regs.continuity = val;
      CFG_BIAS:       shape_regs.bias       = val;
      default:        ;  // unused index, block keeps its settings
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_wen <= 1'b0;
  endtask

  // every word offered, taken and answered
  task automatic wait_drained();
    while (pending_points.size() != 0 || pt_if.valid || expected_points.size() != 0) begin
      @(posedge clk);
    end
  endtask

  initial begin : run_control
    shape_cfg_t setting;
    stim_row_t  row;
    shape_regs     = '0;
    tx_idle_pct    = 6;
    rx_idle_pct    = 84;
    results_seen   = 0;
    mismatch_count = 0;
    rst       <= 1'b1;
    cfg_wen   <= 1'b0;
    cfg_idx   <= CFG_TENSION;
    cfg_wdata <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed rows against the reset settings (catmull-rom)
    for (int i = 0; i < N_DIRECTED; i++) begin
      pending_points.push_back(DIRECTED[i]);
    end
    wait_drained();

    // random phases, one shape setting each; idling shifts from a slow
    // receiver to a slow sender and then to neither side idling
    for (int ph = 0; ph < N_PHASES; ph++) begin
      if (ph < 2) begin
        tx_idle_pct = 6;
        rx_idle_pct = 84;
      end else if (ph < 4) begin
        tx_idle_pct = 84;
        rx_idle_pct = 6;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      if (ph < N_PHASES - 1) begin
        setting = SHAPE_PLAN[ph];
      end else begin
        setting.tension    = shape_t'(int'($urandom_range(32768)) - 16384);
        setting.continuity = shape_t'(int'($urandom_range(32768)) - 16384);
        setting.bias       = shape_t'(int'($urandom_range(32768)) - 16384);
        // a write to the spare index must leave the settings alone
        write_shape_reg(CFG_UNUSED, shape_t'($urandom));
      end
      write_shape_reg(CFG_TENSION, setting.tension);
      write_shape_reg(CFG_CONTINUITY, setting.continuity);
      write_shape_reg(CFG_BIAS, setting.bias);
      end_writes();
      for (int n = 0; n < PHASE_WORDS; n++) begin
        row.pt    = random_point();
        row.known = ROW_CALC;
        row.res   = '0;
        pending_points.push_back(row);
      end
      wait_drained();
    end

    // let any stray word show up before the verdict
    repeat (4 * STAGES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
